[sv/abgs_pkg.sv]
// Shared types, constants and the fixed target table of the auto-brightness unit.
// Used by abgs_div and auto_brightness_gain_and_slew_unit; depends on nothing.
`default_nettype none

package abgs_pkg;

    // Field widths fixed by the interface.
    localparam int GAIN_W       = 8;
    localparam int LEVEL_W      = 8;
    localparam int PERIOD_W     = 7;
    localparam int NUM_POINTS   = 5;
    localparam int MAX_CHANNELS = 8;
    localparam int OUT_CHANNELS = 5;
    localparam int CFG_INDEX_W  = 3;
    localparam int MOVE_W       = 2;

    // Packed result: move, gain, then one level per output channel, padded to bytes.
    localparam int OUT_BITS     = MOVE_W + GAIN_W + OUT_CHANNELS * LEVEL_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Interpolation divider: magnitude of a product of two 8-bit differences
    // divided by an 8-bit difference magnitude.
    localparam int DVD_W        = 16;
    localparam int DVS_W        = 8;
    localparam int TGT_W        = DVD_W + 2;

    typedef logic [GAIN_W-1:0]  gain_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // Request kinds carried on s_tuser.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Reported gain movement.
    typedef enum logic [MOVE_W-1:0] {
        MOVE_NONE = 2'd0,
        MOVE_DOWN = 2'd1,
        MOVE_UP   = 2'd2
    } gain_move_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_LIMIT  = 3'd0,
        CFG_HIGH_LIMIT = 3'd1,
        CFG_PERIOD     = 3'd2,
        CFG_POINT_0    = 3'd3,
        CFG_POINT_1    = 3'd4,
        CFG_POINT_2    = 3'd5,
        CFG_POINT_3    = 3'd6,
        CFG_POINT_4    = 3'd7
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_STEP,
        ST_DONE
    } state_t;

    // Target level of a channel at an interpolation point.
    function automatic level_t target_lut(input logic [2:0] ch, input logic [2:0] pt);
        level_t t;
        t = '0;
        case (ch)
            3'd0, 3'd2: begin
                case (pt)
                    3'd0:    t = 8'h00;
                    3'd1:    t = 8'hff;
                    3'd2:    t = 8'he0;
                    3'd3:    t = 8'h55;
                    3'd4:    t = 8'h0d;
                    default: t = 8'h00;
                endcase
            end
            3'd1: begin
                case (pt)
                    3'd0:    t = 8'h00;
                    3'd1:    t = 8'h38;
                    3'd2:    t = 8'hff;
                    3'd3:    t = 8'hff;
                    3'd4:    t = 8'hff;
                    default: t = 8'h00;
                endcase
            end
            3'd3: begin
                case (pt)
                    3'd0:    t = 8'hff;
                    3'd1:    t = 8'hff;
                    3'd2:    t = 8'hf0;
                    3'd3:    t = 8'he0;
                    3'd4:    t = 8'hc0;
                    default: t = 8'h00;
                endcase
            end
            3'd4: begin
                case (pt)
                    3'd0:    t = 8'h00;
                    3'd1:    t = 8'hff;
                    3'd2:    t = 8'he0;
                    3'd3:    t = 8'h55;
                    3'd4:    t = 8'h14;
                    default: t = 8'h00;
                endcase
            end
            default: t = 8'h00;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[sv/abgs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
`default_nettype none

module abgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 5,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              aclk,
    input  wire              we,
    input  wire [AW-1:0]     waddr,
    input  wire [WIDTH-1:0]  wdata,
    input  wire              re,
    input  wire [AW-1:0]     raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/abgs_div.sv]
// Iterative unsigned divider, two quotient bits per cycle, for the level interpolation.
// Depends on abgs_pkg for the operand widths.
`default_nettype none

module abgs_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [abgs_pkg::DVD_W-1:0]    dividend,
    input  wire [abgs_pkg::DVS_W-1:0]    divisor,
    output logic                         done,
    output logic [abgs_pkg::DVD_W-1:0]   quotient
);

    localparam int STEPS = abgs_pkg::DVD_W / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [abgs_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [abgs_pkg::DVS_W-1:0] dvs_reg;
    logic [abgs_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [abgs_pkg::DVS_W:0]   shifted;
    logic                       last_step;

    // Two restoring steps: shift in a dividend bit, subtract when it fits.
    always_comb begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        shifted  = '0;
        for (int i = 0; i < 2; i++) begin
            shifted  = {rem_next, dvd_next[abgs_pkg::DVD_W-1]};
            dvd_next = {dvd_next[abgs_pkg::DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg}) begin
                shifted     = shifted - {1'b0, dvs_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = shifted[abgs_pkg::DVS_W-1:0];
        end
    end

    assign last_step = (cnt_reg == CNT_W'(STEPS - 1));

    // Control: after a start, run until the last of the STEPS steps, then pulse done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && last_step;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: the dividend register turns into the quotient as it shifts.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

[sv/auto_brightness_gain_and_slew_unit.sv]
// Auto-brightness unit: sensor gain tracking and slew-limited LED levels.
// Depends on abgs_pkg, abgs_ram and abgs_div.
//
// Usage:
//   The s_ channel carries one request per handshake: s_tuser is the kind
//   (0 light sample, 1 tick) and s_tdata the light sample. A sample at or below
//   the low limit lowers the gain by one, at or above the high limit raises it;
//   a tick counts down the slew divider and, when it runs out, steps every channel
//   level by one toward its target interpolated from the gain. Every request
//   returns one result on m_ with the gain move, the gain and all channel levels.
//   The cfg channel writes registers (index, data) and is always ready; write
//   only while no request is in flight.
// Timing:
//   Requests are handled one at a time. The levels live in a RAM and are
//   read, updated and written back one channel after another, through the states
//   READ, LOAD and STEP; when the target needs the shared two-bit-per-cycle
//   divider, the states MUL and DIV lie between LOAD and STEP.
//   The result sits in an output register; a new request is taken while it
//   waits, and the sequencer stalls at its end until m_tready frees the register.
// Reset: aresetn (synchronous, active low) loads the register defaults, sets
//   the gain to GAIN_LOWEST, the divider to zero and all levels to zero.
`default_nettype none

module auto_brightness_gain_and_slew_unit #(
    parameter int GAIN_LOWEST   = 1,
    parameter int GAIN_HIGHEST  = 255,
    parameter int CHANNEL_COUNT = 5
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Request channel.
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [7:0]                          s_tdata,   // [7:0] light_sample
    input  wire [0:0]                          s_tuser,   // [0] op
    // Result channel.
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [1:0] gain_move, [9:2] gain_now, [17:10] level_skull_white,
    // [25:18] level_skull_purple, [33:26] level_bones, [41:34] level_eyes,
    // [49:42] level_backlight, [55:50] zero
    output logic [abgs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration write channel.
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [abgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [7:0]                          cfg_data
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam abgs_pkg::gain_t GAIN_LO = abgs_pkg::gain_t'(GAIN_LOWEST);
    localparam abgs_pkg::gain_t GAIN_HI = abgs_pkg::gain_t'(GAIN_HIGHEST);
    localparam int LVL_BASE = abgs_pkg::MOVE_W + abgs_pkg::GAIN_W;

    // Configuration registers.
    abgs_pkg::gain_t             low_limit_reg;
    abgs_pkg::gain_t             high_limit_reg;
    logic [abgs_pkg::PERIOD_W-1:0] period_reg;
    abgs_pkg::gain_t             point_reg [abgs_pkg::NUM_POINTS];

    // Request state.
    abgs_pkg::state_t            state_reg, state_next;
    abgs_pkg::gain_t             gain_reg;
    logic [abgs_pkg::PERIOD_W-1:0] tick_cnt_reg;
    abgs_pkg::gain_move_t        move_reg;
    logic                        step_reg;
    logic [CH_W-1:0]             ch_reg;
    logic                        lvl_valid_reg [CHANNEL_COUNT];

    // Per-channel work registers.
    abgs_pkg::level_t            lvl_reg;
    abgs_pkg::level_t            base_reg;
    logic                        hold_reg;
    logic                        use_div_reg;
    logic                        neg_reg;
    logic [7:0]                  dx_mag_reg, dy_mag_reg, dvs_reg;
    abgs_pkg::level_t            res_reg [abgs_pkg::OUT_CHANNELS];

    // Output register.
    logic                        m_tvalid_reg;
    logic [abgs_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // Sequencer controls.
    logic                        s_accept;
    logic                        ram_re;
    logic                        ram_we;
    logic                        div_start;
    logic                        out_load;
    logic                        ch_last;

    // RAM and divider connections.
    abgs_pkg::level_t            ram_rdata;
    logic                        div_done;
    logic [abgs_pkg::DVD_W-1:0]  div_quot;

    // Segment selection.
    abgs_pkg::level_t            lvl_in;
    logic                        sel_hold;
    logic                        sel_div;
    abgs_pkg::level_t            sel_base;
    logic                        sel_neg;
    logic [7:0]                  sel_dx, sel_dy, sel_dvs;
    logic                        seg_hit;
    abgs_pkg::gain_t             seg_x0, seg_x1;
    abgs_pkg::level_t            seg_y0, seg_y1;
    logic [8:0]                  diff_x, diff_y, diff_p;

    // Step computation.
    logic signed [abgs_pkg::TGT_W-1:0] q_signed;
    logic signed [abgs_pkg::TGT_W-1:0] tgt_raw;
    abgs_pkg::level_t            tgt_clamped;
    abgs_pkg::level_t            lvl_new;

    logic [abgs_pkg::OUT_TDATA_W-1:0] tdata_pack;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign ch_last   = (int'(ch_reg) == CHANNEL_COUNT - 1);

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= 8'd16;
            high_limit_reg <= 8'd240;
            period_reg     <= 7'd1;
            point_reg[0]   <= 8'd1;
            point_reg[1]   <= 8'd16;
            point_reg[2]   <= 8'd32;
            point_reg[3]   <= 8'd64;
            point_reg[4]   <= 8'd128;
        end else if (cfg_valid && cfg_ready) begin
            unique case (abgs_pkg::cfg_index_t'(cfg_index))
                abgs_pkg::CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                abgs_pkg::CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                abgs_pkg::CFG_PERIOD:     period_reg     <= cfg_data[abgs_pkg::PERIOD_W-1:0];
                abgs_pkg::CFG_POINT_0:    point_reg[0]   <= cfg_data;
                abgs_pkg::CFG_POINT_1:    point_reg[1]   <= cfg_data;
                abgs_pkg::CFG_POINT_2:    point_reg[2]   <= cfg_data;
                abgs_pkg::CFG_POINT_3:    point_reg[3]   <= cfg_data;
                abgs_pkg::CFG_POINT_4:    point_reg[4]   <= cfg_data;
            endcase
        end
    end

    // Level storage and the shared interpolation divider.
    abgs_ram #(
        .WIDTH (abgs_pkg::LEVEL_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_level_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (lvl_new),
        .re    (ram_re),
        .raddr (ch_reg),
        .rdata (ram_rdata)
    );

    abgs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({8'd0, dx_mag_reg} * {8'd0, dy_mag_reg}),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abgs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and controls.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            abgs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = abgs_pkg::ST_READ;
                end
            end
            abgs_pkg::ST_READ: begin
                ram_re     = 1'b1;
                state_next = abgs_pkg::ST_LOAD;
            end
            abgs_pkg::ST_LOAD: begin
                state_next = sel_div ? abgs_pkg::ST_MUL : abgs_pkg::ST_STEP;
            end
            abgs_pkg::ST_MUL: begin
                div_start  = 1'b1;
                state_next = abgs_pkg::ST_DIV;
            end
            abgs_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = abgs_pkg::ST_STEP;
                end
            end
            abgs_pkg::ST_STEP: begin
                ram_we     = !hold_reg;
                state_next = ch_last ? abgs_pkg::ST_DONE : abgs_pkg::ST_READ;
            end
            abgs_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = abgs_pkg::ST_IDLE;
                end
            end
            default: state_next = abgs_pkg::ST_IDLE;
        endcase
    end

    // Gain, slew divider, channel pointer: set on a request, pointer moved in STEP.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_LO;
            tick_cnt_reg <= '0;
            move_reg     <= abgs_pkg::MOVE_NONE;
            step_reg     <= 1'b0;
            ch_reg       <= '0;
        end else begin
            if (s_accept) begin
                ch_reg   <= '0;
                move_reg <= abgs_pkg::MOVE_NONE;
                step_reg <= 1'b0;
                if (s_tuser[0] == abgs_pkg::OP_TICK) begin
                    // A run-out divider reloads from the period, zero acting as one.
                    if (tick_cnt_reg == '0) begin
                        step_reg     <= 1'b1;
                        tick_cnt_reg <= (period_reg == '0) ? '0
                                        : period_reg - abgs_pkg::PERIOD_W'(1);
                    end else begin
                        tick_cnt_reg <= tick_cnt_reg - abgs_pkg::PERIOD_W'(1);
                    end
                end else if (s_tdata <= low_limit_reg) begin
                    if (gain_reg > GAIN_LO) begin
                        gain_reg <= gain_reg - abgs_pkg::gain_t'(1);
                        move_reg <= abgs_pkg::MOVE_DOWN;
                    end
                end else if (s_tdata >= high_limit_reg) begin
                    if (gain_reg < GAIN_HI) begin
                        gain_reg <= gain_reg + abgs_pkg::gain_t'(1);
                        move_reg <= abgs_pkg::MOVE_UP;
                    end
                end
            end else if (state_reg == abgs_pkg::ST_STEP && !ch_last) begin
                ch_reg <= ch_reg + CH_W'(1);
            end
        end
    end

    // Valid bits stand in for the zero reset of the level RAM.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                lvl_valid_reg[c] <= 1'b0;
            end
        end else if (ram_we) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                if (int'(ch_reg) == c) begin
                    lvl_valid_reg[c] <= 1'b1;
                end
            end
        end
    end

    // Pick the interpolation segment for the current gain and channel.
    always_comb begin
        lvl_in  = lvl_valid_reg[ch_reg] ? ram_rdata : '0;
        seg_hit = 1'b0;
        seg_x0  = point_reg[0];
        seg_x1  = point_reg[1];
        seg_y0  = abgs_pkg::target_lut(3'(ch_reg), 3'd0);
        seg_y1  = abgs_pkg::target_lut(3'(ch_reg), 3'd1);
        for (int k = 1; k < abgs_pkg::NUM_POINTS; k++) begin
            if (!seg_hit && gain_reg <= point_reg[k]) begin
                seg_hit = 1'b1;
                seg_x0  = point_reg[k-1];
                seg_x1  = point_reg[k];
                seg_y0  = abgs_pkg::target_lut(3'(ch_reg), 3'(k - 1));
                seg_y1  = abgs_pkg::target_lut(3'(ch_reg), 3'(k));
            end
        end
        diff_x   = {1'b0, gain_reg} - {1'b0, seg_x0};
        diff_y   = {1'b0, seg_y1} - {1'b0, seg_y0};
        diff_p   = {1'b0, seg_x1} - {1'b0, seg_x0};
        sel_dx   = diff_x[8] ? 8'(-diff_x) : diff_x[7:0];
        sel_dy   = diff_y[8] ? 8'(-diff_y) : diff_y[7:0];
        sel_dvs  = diff_p[8] ? 8'(-diff_p) : diff_p[7:0];
        sel_neg  = diff_x[8] ^ diff_y[8] ^ diff_p[8];
        sel_hold = 1'b0;
        sel_div  = 1'b0;
        sel_base = seg_y0;
        priority if (!step_reg || gain_reg == '0) begin
            sel_hold = 1'b1;
        end else if (gain_reg == point_reg[0]) begin
            sel_base = abgs_pkg::target_lut(3'(ch_reg), 3'd0);
        end else if (!seg_hit) begin
            sel_hold = 1'b1;
        end else if (seg_x1 == seg_x0) begin
            // Equal neighboring points: take the upper target.
            sel_base = seg_y1;
        end else begin
            sel_div = 1'b1;
        end
    end

    // Per-channel work registers.
    always_ff @(posedge aclk) begin
        if (state_reg == abgs_pkg::ST_LOAD) begin
            lvl_reg     <= lvl_in;
            base_reg    <= sel_base;
            hold_reg    <= sel_hold;
            use_div_reg <= sel_div;
            neg_reg     <= sel_neg;
            dx_mag_reg  <= sel_dx;
            dy_mag_reg  <= sel_dy;
            dvs_reg     <= sel_dvs;
        end
    end

    // Target from base and signed quotient, clamped, then one step toward it unless held.
    always_comb begin
        q_signed = use_div_reg ? $signed({2'b00, div_quot}) : '0;
        if (neg_reg) begin
            q_signed = -q_signed;
        end
        tgt_raw = $signed({{(abgs_pkg::TGT_W - abgs_pkg::LEVEL_W){1'b0}}, base_reg}) + q_signed;
        priority if (tgt_raw < 0) begin
            tgt_clamped = '0;
        end else if (tgt_raw > abgs_pkg::TGT_W'(255)) begin
            tgt_clamped = 8'hff;
        end else begin
            tgt_clamped = tgt_raw[abgs_pkg::LEVEL_W-1:0];
        end
        priority if (hold_reg) begin
            lvl_new = lvl_reg;
        end else if (lvl_reg > tgt_clamped) begin
            lvl_new = lvl_reg - abgs_pkg::level_t'(1);
        end else if (lvl_reg < tgt_clamped) begin
            lvl_new = lvl_reg + abgs_pkg::level_t'(1);
        end else begin
            lvl_new = lvl_reg;
        end
    end

    // Collect the levels of the output channels for the result.
    always_ff @(posedge aclk) begin
        if (state_reg == abgs_pkg::ST_STEP) begin
            for (int j = 0; j < abgs_pkg::OUT_CHANNELS; j++) begin
                if (int'(ch_reg) == j) begin
                    res_reg[j] <= lvl_new;
                end
            end
        end
    end

    // Pack the result; channels that do not exist read as zero.
    always_comb begin
        tdata_pack = '0;
        tdata_pack[abgs_pkg::MOVE_W-1:0] = move_reg;
        tdata_pack[LVL_BASE-1:abgs_pkg::MOVE_W] = gain_reg;
        for (int j = 0; j < abgs_pkg::OUT_CHANNELS; j++) begin
            if (j < CHANNEL_COUNT) begin
                tdata_pack[LVL_BASE + j*abgs_pkg::LEVEL_W +: abgs_pkg::LEVEL_W] = res_reg[j];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= tdata_pack;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The gain stays within its bounds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (gain_reg >= GAIN_LO) && (gain_reg <= GAIN_HI))
        else $error("gain left its bounds");

    // The gain changes only when a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(gain_reg))
        else $error("gain changed without a request");

    // Levels are written back only on a request that steps the levels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> step_reg)
        else $error("level written on a request without a step");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == abgs_pkg::ST_DIV))
        else $error("divider result arrived outside the wait state");

endmodule

`default_nettype wire

[tb/auto_brightness_gain_and_slew_unit_tb.sv]
// Self-checking testbench for auto_brightness_gain_and_slew_unit.
// Holds its own prediction of gain tracking and level slewing; depends on abgs_pkg and the RTL.
`timescale 1ns / 1ps

module auto_brightness_gain_and_slew_unit_tb;
    import abgs_pkg::*;

    localparam int GAIN_LOWEST   = 1;
    localparam int GAIN_HIGHEST  = 255;
    localparam int CHANNEL_COUNT = 5;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int TAIL_CYCLES   = 80;
    localparam int LEVEL_LSB     = MOVE_W + GAIN_W;

    // Target level of each channel (row) at each gain point (column).
    localparam logic [0:4][0:4][7:0] LEVEL_TARGETS = '{
        '{8'h00, 8'hff, 8'he0, 8'h55, 8'h0d},
        '{8'h00, 8'h38, 8'hff, 8'hff, 8'hff},
        '{8'h00, 8'hff, 8'he0, 8'h55, 8'h0d},
        '{8'hff, 8'hff, 8'hf0, 8'he0, 8'hc0},
        '{8'h00, 8'hff, 8'he0, 8'h55, 8'h14}
    };

    // One result as the block reports it.
    typedef struct {
        gain_move_t move;
        gain_t      gain;
        level_t     level [OUT_CHANNELS];
    } readout_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // Predicted register settings and block state.
    logic [7:0] lim_low;
    logic [7:0] lim_high;
    logic [6:0] slew_period;
    logic [7:0] gain_points [NUM_POINTS];
    logic [7:0] gain_track;
    logic [6:0] tick_count;
    logic [7:0] level_track [OUT_CHANNELS];

    readout_t readouts_due [$];
    int       fault_count;
    int       cycle_count;
    int       sender_idle_pct;
    int       receiver_stall_pct;

    auto_brightness_gain_and_slew_unit #(
        .GAIN_LOWEST   (GAIN_LOWEST),
        .GAIN_HIGHEST  (GAIN_HIGHEST),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Interpolated, clamped target of one channel; -1 when the level holds.
    function automatic int level_target(input int ch);
        int g;
        int x0;
        int x1;
        int y0;
        int y1;
        int t;
        bit hit;
        g   = gain_track;
        t   = 0;
        hit = 1'b0;
        if (g == 0)
            return -1;
        if (g == gain_points[0]) begin
            t   = LEVEL_TARGETS[ch][0];
            hit = 1'b1;
        end else begin
            for (int k = 1; k < NUM_POINTS; k++) begin
                if (g <= gain_points[k]) begin
                    x0 = gain_points[k-1];
                    x1 = gain_points[k];
                    y0 = LEVEL_TARGETS[ch][k-1];
                    y1 = LEVEL_TARGETS[ch][k];
                    if (x1 == x0)
                        t = y1;
                    else
                        t = y0 + ((g - x0) * (y1 - y0)) / (x1 - x0);
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (!hit)
            return -1;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t;
    endfunction

    // Applies one request to the predicted state and returns the expected readout.
    function automatic readout_t advance_model(input op_t op, input logic [7:0] light);
        readout_t r;
        int       tgt;
        r.move = MOVE_NONE;
        if (op == OP_SAMPLE) begin
            if (light <= lim_low) begin
                if (gain_track > GAIN_LOWEST) begin
                    gain_track = gain_track - 8'd1;
                    r.move     = MOVE_DOWN;
                end
            end else if (light >= lim_high) begin
                if (gain_track < GAIN_HIGHEST) begin
                    gain_track = gain_track + 8'd1;
                    r.move     = MOVE_UP;
                end
            end
        end else begin
            // The divider reloads and every channel slews once when it has run out.
            if (tick_count == 7'd0) begin
                tick_count = (slew_period == 7'd0) ? 7'd1 : slew_period;
                for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                    tgt = level_target(ch);
                    if (tgt >= 0 && int'(level_track[ch]) > tgt)
                        level_track[ch] = level_track[ch] - 8'd1;
                    else if (tgt >= 0 && int'(level_track[ch]) < tgt)
                        level_track[ch] = level_track[ch] + 8'd1;
                end
            end
            tick_count = tick_count - 7'd1;
        end
        r.gain = gain_track;
        for (int ch = 0; ch < OUT_CHANNELS; ch++)
            r.level[ch] = (ch < CHANNEL_COUNT) ? level_track[ch] : 8'd0;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Compare every accepted result with the oldest pending readout.
    always @(posedge aclk) begin : check_readout
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (readouts_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("[%0t] result with no request pending: %h", $time, m_tdata);
            end else begin
                want = readouts_due.pop_front();
                if (m_tdata[MOVE_W-1:0] !== want.move)
                    note_mismatch("gain_move", 8'(want.move), 8'(m_tdata[MOVE_W-1:0]));
                if (m_tdata[MOVE_W +: GAIN_W] !== want.gain)
                    note_mismatch("gain_now", want.gain, m_tdata[MOVE_W +: GAIN_W]);
                for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
                    if (m_tdata[LEVEL_LSB + ch*LEVEL_W +: LEVEL_W] !== want.level[ch])
                        note_mismatch($sformatf("level of channel %0d", ch), want.level[ch],
                                      m_tdata[LEVEL_LSB + ch*LEVEL_W +: LEVEL_W]);
                end
                if (m_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0)
                    note_mismatch("padding", 8'd0, 8'(m_tdata[OUT_TDATA_W-1:OUT_BITS]));
            end
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("auto_brightness_gain_and_slew_unit regression: fail");
        $finish;
    end

    // Sends one request, called and returning at a falling edge; valid stays high after it.
    task automatic send_request(input op_t op, input logic [7:0] light);
        readout_t due;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= light;
        do @(posedge aclk); while (!s_tready);
        due = advance_model(op, light);
        readouts_due.push_back(due);
        @(negedge aclk);
    endtask

    // Stops sending and waits until every pending readout has come back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (readouts_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LOW_LIMIT:  lim_low        = value;
            CFG_HIGH_LIMIT: lim_high       = value;
            CFG_PERIOD:     slew_period    = value[6:0];
            CFG_POINT_0:    gain_points[0] = value;
            CFG_POINT_1:    gain_points[1] = value;
            CFG_POINT_2:    gain_points[2] = value;
            CFG_POINT_3:    gain_points[3] = value;
            CFG_POINT_4:    gain_points[4] = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Writes all registers once the block has gone idle.
    task automatic reconfigure(input logic [7:0] low, input logic [7:0] high,
                               input logic [6:0] period, input logic [7:0] p0,
                               input logic [7:0] p1, input logic [7:0] p2,
                               input logic [7:0] p3, input logic [7:0] p4);
        drain_requests();
        write_register(CFG_LOW_LIMIT, low);
        write_register(CFG_HIGH_LIMIT, high);
        write_register(CFG_PERIOD, {1'b0, period});
        write_register(CFG_POINT_0, p0);
        write_register(CFG_POINT_1, p1);
        write_register(CFG_POINT_2, p2);
        write_register(CFG_POINT_3, p3);
        write_register(CFG_POINT_4, p4);
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: gain at its lower bound, exact limits, first tick slews at once.
    task automatic test_reset_state();
        send_request(OP_SAMPLE, 8'd0);
        send_request(OP_TICK, 8'd0);
        send_request(OP_SAMPLE, 8'd255);
        send_request(OP_SAMPLE, 8'd128);
        send_request(OP_SAMPLE, 8'd16);
        send_request(OP_SAMPLE, 8'd240);
        send_request(OP_TICK, 8'hff);
    endtask

    // A period of zero behaves like one: every tick slews.
    task automatic test_period_zero();
        reconfigure(8'd16, 8'd240, 7'd0, 8'd1, 8'd16, 8'd32, 8'd64, 8'd128);
        repeat (3) send_request(OP_TICK, 8'h5a);
    endtask

    // Limits that overlap: the low limit wins for a sample that meets both.
    task automatic test_both_limits();
        reconfigure(8'd200, 8'd100, 7'd1, 8'd1, 8'd16, 8'd32, 8'd64, 8'd128);
        send_request(OP_SAMPLE, 8'd150);
        send_request(OP_SAMPLE, 8'd50);
        send_request(OP_SAMPLE, 8'd255);
    endtask

    // Equal neighbor points, extrapolation clamped low and high, gain above
    // every point, and gain equal to the first point.
    task automatic test_interpolation_corners();
        reconfigure(8'd16, 8'd240, 7'd1, 8'd5, 8'd5, 8'd32, 8'd64, 8'd128);
        send_request(OP_TICK, 8'd0);
        reconfigure(8'd16, 8'd240, 7'd1, 8'd10, 8'd16, 8'd32, 8'd64, 8'd128);
        send_request(OP_TICK, 8'd0);
        reconfigure(8'd16, 8'd240, 7'd1, 8'd200, 8'd100, 8'd150, 8'd180, 8'd250);
        send_request(OP_TICK, 8'd0);
        reconfigure(8'd16, 8'd240, 7'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(OP_TICK, 8'd0);
        reconfigure(8'd16, 8'd240, 7'd1, 8'd2, 8'd16, 8'd32, 8'd64, 8'd128);
        send_request(OP_TICK, 8'd0);
    endtask

    // Random requests; up_pct of samples land at or above the high limit.
    task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                             input int tick_pct, input int up_pct);
        op_t        op;
        logic [7:0] light;
        int         pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) begin
            op   = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE;
            pick = $urandom_range(0, 99);
            if (pick < up_pct)
                light = 8'($urandom_range(int'(lim_high), 255));
            else if (pick < up_pct + 10)
                case ($urandom_range(0, 3))
                    0:       light = lim_low;
                    1:       light = lim_low + 8'd1;
                    2:       light = lim_high - 8'd1;
                    default: light = lim_high;
                endcase
            else
                light = 8'($urandom_range(0, 255));
            send_request(op, light);
        end
    endtask

    // Gain climbs toward its upper bound, then falls back.
    task automatic test_random_traffic();
        reconfigure(8'd0, 8'd0, 7'd1, 8'd1, 8'd16, 8'd32, 8'd64, 8'd128);
        run_phase(100, 0, 0, 10, 85);
        reconfigure(8'd0, 8'd2, 7'd2, 8'd0, 8'd40, 8'd90, 8'd160, 8'd255);
        run_phase(100, 50, 0, 10, 85);
        reconfigure(8'd5, 8'd100, 7'd5, 8'd20, 8'd60, 8'd140, 8'd200, 8'd250);
        run_phase(90, 0, 50, 20, 90);
        reconfigure(8'd255, 8'd255, 7'd3, 8'd180, 8'd120, 8'd240, 8'd40, 8'd90);
        run_phase(90, 34, 34, 35, 0);
        reconfigure(8'd64, 8'd192, 7'd1, 8'd1, 8'd16, 8'd32, 8'd64, 8'd128);
        run_phase(90, 0, 0, 40, 40);
        reconfigure(8'd100, 8'd120, 7'd4, 8'd30, 8'd30, 8'd80, 8'd80, 8'd200);
        run_phase(90, 34, 34, 40, 30);
    endtask

    // The longest period: one slew, then the divider holds further ticks back.
    task automatic test_period_ceiling();
        reconfigure(8'd16, 8'd240, 7'd127, 8'd1, 8'd16, 8'd32, 8'd64, 8'd128);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (5) send_request(OP_TICK, 8'h33);
        send_request(OP_SAMPLE, 8'd0);
    endtask

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = OP_SAMPLE;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_LOW_LIMIT;
        cfg_data           = '0;
        m_tready           = 1'b0;
        fault_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        // Predicted state after reset.
        lim_low        = 8'd16;
        lim_high       = 8'd240;
        slew_period    = 7'd1;
        gain_points[0] = 8'd1;
        gain_points[1] = 8'd16;
        gain_points[2] = 8'd32;
        gain_points[3] = 8'd64;
        gain_points[4] = 8'd128;
        gain_track     = 8'(GAIN_LOWEST);
        tick_count     = 7'd0;
        for (int ch = 0; ch < OUT_CHANNELS; ch++)
            level_track[ch] = 8'd0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_period_zero();
        test_both_limits();
        test_interpolation_corners();
        test_random_traffic();
        test_period_ceiling();

        // Let everything come back, then watch for stray results.
        drain_requests();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0 && readouts_due.size() == 0)
            $display("auto_brightness_gain_and_slew_unit regression: pass");
        else
            $display("auto_brightness_gain_and_slew_unit regression: fail");
        $finish;
    end

endmodule
